// ===== hw/rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Operation codes, status codes and widths shared by the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int OP_BITS     = 3;
   localparam int POS_BITS    = 4;
   localparam int FIELD_BITS  = 32;
   localparam int OCC_BITS    = 5;
   localparam int STATUS_BITS = 2;
   localparam int REQ_BITS    = 40;
   localparam int RSP_BITS    = 104;

   typedef logic [OP_BITS-1:0]     op_type;
   typedef logic [STATUS_BITS-1:0] status_type;
   typedef logic [1:0]             target_type;

   localparam op_type OP_PUSH_BACK  = 3'd0;
   localparam op_type OP_PUSH_FRONT = 3'd1;
   localparam op_type OP_POP_BACK   = 3'd2;
   localparam op_type OP_POP_FRONT  = 3'd3;
   localparam op_type OP_READ_AT    = 3'd4;
   localparam op_type OP_WRITE_AT   = 3'd5;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;
   localparam status_type ST_RANGE = 2'd3;

   // where the word coming back from the ring goes
   localparam target_type TGT_FRONT = 2'd0;
   localparam target_type TGT_BACK  = 2'd1;
   localparam target_type TGT_READ  = 2'd2;

endpackage

// ===== hw/rtl/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// bdq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/bounded_deque_with_index.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_index
// Bounded double-ended queue in a ring RAM with a head pointer and a count.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  req_    | in        | op, data_in, position
//  rsp_    | out       | front_word, back_word, read_word, occupancy, status
//
// Pushes, write-at and rejected operations build their result straight from the request. Pops that leave
// two or more entries and read-at pass through S_READ: the word comes from the
// single read port of the ring RAM in the cycle after its address.
// Front and back words are kept in registers beside the RAM.
// Reset clears head, count and the front/back registers; the RAM is not
// cleared. A stalled result holds in the output register and blocks input.
// ----------------------------------------------------------------------------
module bounded_deque_with_index
   import bdq_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // op[2:0], data_in[34:3], position[38:35], zero [39]
   input  logic [REQ_BITS-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // front_word[31:0], back_word[63:32], read_word[95:64],
   // occupancy[100:96], status[102:101], zero [103]
   output logic [RSP_BITS-1:0] rsp_tdata
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic                        state_ff, state_in;
   logic [PTR_W-1:0]            head_ff, head_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic signed [WORD_BITS-1:0] front_ff, front_in;
   logic signed [WORD_BITS-1:0] back_ff, back_in;
   status_type                  status_ff, status_in;
   target_type                  target_ff, target_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]         rsp_data_ff, rsp_data_in;

   op_type                      op;
   logic signed [FIELD_BITS-1:0] din;
   logic [POS_BITS-1:0]         pos;
   logic signed [WORD_BITS-1:0] data_word;
   logic                        accept;
   logic                        empty, full, out_of_range, pos_last;
   logic [PTR_W-1:0]            offset, slot, head_dec;
   logic [PTR_W:0]              slot_sum;
   logic                        need_read;
   logic                        wr_en;
   logic [PTR_W-1:0]            wr_addr;
   logic [WORD_BITS-1:0]        rd_data;
   logic signed [WORD_BITS-1:0] rd_word;
   logic signed [WORD_BITS-1:0] read_val;

   assign op        = req_tdata[2:0];
   assign din       = signed'(req_tdata[34:3]);
   assign pos       = req_tdata[38:35];
   assign data_word = WORD_BITS'(din);
   assign rd_word   = signed'(rd_data);

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign empty        = (count_ff == '0);
   assign full         = (count_ff == CNT_W'(DEPTH));
   assign out_of_range = (CMP_W'(pos) >= CMP_W'(count_ff));
   assign pos_last     = (CMP_W'(pos) == (CMP_W'(count_ff) - CMP_W'(1)));

   // ring slot at head + offset, offset below DEPTH
   always_comb begin
      case (op)
         OP_PUSH_BACK: offset = PTR_W'(count_ff);
         OP_POP_BACK:  offset = PTR_W'(count_ff - CNT_W'(2));
         OP_POP_FRONT: offset = PTR_W'(1);
         default:      offset = PTR_W'(pos);
      endcase
      slot_sum = {1'b0, head_ff} + {1'b0, offset};
      if (slot_sum >= (PTR_W + 1)'(DEPTH)) begin
         slot = PTR_W'(slot_sum - (PTR_W + 1)'(DEPTH));
      end else begin
         slot = PTR_W'(slot_sum);
      end
      head_dec = (head_ff == '0) ? PTR_W'(DEPTH - 1) : head_ff - PTR_W'(1);
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      status_in    = status_ff;
      target_in    = target_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      need_read    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = slot;
      read_val     = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = ST_OK;
               case (op)
                  OP_PUSH_BACK: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        back_in  = data_word;
                        if (empty) begin
                           front_in = data_word;
                        end
                     end
                  end
                  OP_PUSH_FRONT: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = head_dec;
                        head_in  = head_dec;
                        count_in = count_ff + CNT_W'(1);
                        front_in = data_word;
                        if (empty) begin
                           back_in = data_word;
                        end
                     end
                  end
                  OP_POP_BACK: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        if (count_ff == CNT_W'(1)) begin
                           front_in = '0;
                           back_in  = '0;
                        end else if (count_ff == CNT_W'(2)) begin
                           back_in = front_ff;
                        end else begin
                           need_read = 1'b1;
                           target_in = TGT_BACK;
                        end
                     end
                  end
                  OP_POP_FRONT: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        head_in  = slot;
                        if (count_ff == CNT_W'(1)) begin
                           front_in = '0;
                           back_in  = '0;
                        end else if (count_ff == CNT_W'(2)) begin
                           front_in = back_ff;
                        end else begin
                           need_read = 1'b1;
                           target_in = TGT_FRONT;
                        end
                     end
                  end
                  OP_READ_AT: begin
                     if (out_of_range) begin
                        status_in = ST_RANGE;
                     end else begin
                        need_read = 1'b1;
                        target_in = TGT_READ;
                     end
                  end
                  OP_WRITE_AT: begin
                     if (out_of_range) begin
                        status_in = ST_RANGE;
                     end else begin
                        wr_en = 1'b1;
                        if (pos == '0) begin
                           front_in = data_word;
                        end
                        if (pos_last) begin
                           back_in = data_word;
                        end
                     end
                  end
                  default: begin
                  end
               endcase

               if (need_read) begin
                  state_in = S_READ;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {1'b0, status_in, OCC_BITS'(count_in),
                                  FIELD_BITS'(read_val), FIELD_BITS'(back_in),
                                  FIELD_BITS'(front_in)};
               end
            end
         end
         S_READ: begin
            // fold the word from the ring into the result
            case (target_ff)
               TGT_FRONT: front_in = rd_word;
               TGT_BACK:  back_in  = rd_word;
               default:   read_val = rd_word;
            endcase
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_data_in  = {1'b0, status_ff, OCC_BITS'(count_ff),
                            FIELD_BITS'(read_val), FIELD_BITS'(back_in),
                            FIELD_BITS'(front_in)};
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   bdq_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (data_word),
      .rd_en   (need_read),
      .rd_addr (slot),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         front_ff     <= '0;
         back_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      target_ff   <= target_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= PTR_W'(DEPTH - 1))
      else $error("head pointer outside the ring");

   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> !rsp_valid_ff)
      else $error("ring read pending while output register is full");

   a_read_follows: assert property (@(posedge clock) disable iff (reset)
      accept && need_read |=> state_ff == S_READ && !req_tready)
      else $error("ring read not followed by its completion cycle");

   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      need_read |-> !wr_en)
      else $error("ring written and read by the same transaction");

endmodule

// ===== tb/sv/deque_checker.sv =====
// ----------------------------------------------------------------------------
// deque_checker
// Watches the request and response streams of the bounded deque, keeps its
// own copy of the ring, head and count, predicts every response and compares
// it field by field against what the block returns.
// ----------------------------------------------------------------------------
module deque_checker
   import bdq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   // op[2:0], data_in[34:3], position[38:35], zero [39]
   input  logic [REQ_BITS-1:0] req_tdata,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   // front_word[31:0], back_word[63:32], read_word[95:64],
   // occupancy[100:96], status[102:101], zero [103]
   input  logic [RSP_BITS-1:0] rsp_tdata,
   output int                  mismatches,
   output int                  outstanding,
   output int                  checked,
   output logic [OCC_BITS-1:0] model_count,
   output int                  empty_hits,
   output int                  full_hits,
   output int                  range_hits
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 16;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] front_word;
      logic signed [FIELD_BITS-1:0] back_word;
      logic signed [FIELD_BITS-1:0] read_word;
      logic [OCC_BITS-1:0]          occupancy;
      status_type                   status;
   } deque_view_type;

   logic signed [FIELD_BITS-1:0] ring [SLOTS];
   logic [POS_BITS-1:0]          head;
   logic [OCC_BITS-1:0]          count;
   deque_view_type               pending_views [$];
   deque_view_type               want;
   deque_view_type               got;

   assign model_count = count;

   initial begin
      mismatches = 0;
      outstanding = 0;
      checked = 0;
      empty_hits = 0;
      full_hits = 0;
      range_hits = 0;
      head = '0;
      count = '0;
   end

   // offsets wrap in the 4-bit slot index
   function automatic logic [POS_BITS-1:0] slot_at(input logic [POS_BITS-1:0] offset);
      slot_at = head + offset;
   endfunction

   task automatic apply_op(input op_type op, input logic signed [FIELD_BITS-1:0] word,
                           input logic [POS_BITS-1:0] pos, output deque_view_type v);
      status_type                   st;
      logic signed [FIELD_BITS-1:0] rd;
      st = ST_OK;
      rd = '0;
      case (op)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (count == SLOTS) begin
               st = ST_FULL;
            end else if (op == OP_PUSH_BACK) begin
               ring[slot_at(count[POS_BITS-1:0])] = word;
               count = count + 1'b1;
            end else begin
               head = head - 1'b1;
               ring[head] = word;
               count = count + 1'b1;
            end
         end
         OP_POP_BACK, OP_POP_FRONT: begin
            if (count == 0) begin
               st = ST_EMPTY;
            end else begin
               if (op == OP_POP_FRONT) head = head + 1'b1;
               count = count - 1'b1;
            end
         end
         OP_READ_AT: begin
            if ({1'b0, pos} >= count) st = ST_RANGE;
            else rd = ring[slot_at(pos)];
         end
         OP_WRITE_AT: begin
            if ({1'b0, pos} >= count) st = ST_RANGE;
            else ring[slot_at(pos)] = word;
         end
         default: ;
      endcase
      case (st)
         ST_EMPTY: empty_hits++;
         ST_FULL:  full_hits++;
         ST_RANGE: range_hits++;
         default: ;
      endcase
      if (count == 0) begin
         v.front_word = '0;
         v.back_word = '0;
      end else begin
         v.front_word = ring[head];
         v.back_word = ring[slot_at(POS_BITS'(count - 1'b1))];
      end
      v.read_word = rd;
      v.occupancy = count;
      v.status = st;
   endtask

   task automatic check_field(input string name, input logic [FIELD_BITS-1:0] exp_val,
                              input logic [FIELD_BITS-1:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t ns: %s expected %0d (0x%08h), got %0d (0x%08h)", $time, name,
                  $signed(exp_val), exp_val, $signed(act_val), act_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         head = '0;
         count = '0;
         pending_views.delete();
      end else begin
         // the result can never belong to an item accepted on this same edge
         if (rsp_tvalid && rsp_tready) begin
            got.front_word = rsp_tdata[31:0];
            got.back_word = rsp_tdata[63:32];
            got.read_word = rsp_tdata[95:64];
            got.occupancy = rsp_tdata[100:96];
            got.status = rsp_tdata[102:101];
            if (pending_views.size() == 0) begin
               $display("%0t ns: unexpected response transaction, expected none, got 0x%026h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = pending_views[0];
               pending_views.delete(0);
               check_field("front_word", want.front_word, got.front_word);
               check_field("back_word", want.back_word, got.back_word);
               check_field("read_word", want.read_word, got.read_word);
               check_field("occupancy", FIELD_BITS'(want.occupancy), FIELD_BITS'(got.occupancy));
               check_field("status", FIELD_BITS'(want.status), FIELD_BITS'(got.status));
               checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            apply_op(req_tdata[2:0], req_tdata[34:3], req_tdata[38:35], want);
            pending_views.insert(pending_views.size(), want);
         end
      end
      outstanding = pending_views.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the bounded deque: a directed pass over empty, full-range and
// rejected operations, then random fill, drain and mixed phases with random
// idle gaps and response stalls. A checker beside the block scores results.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bdq_pkg::*;

   localparam op_type OP_SPARE_6 = 3'd6;
   localparam op_type OP_SPARE_7 = 3'd7;
   localparam int     RANDOM_ITEMS = 1550;

   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_BITS-1:0] rsp_tdata;

   int                  mismatches;
   int                  outstanding;
   int                  checked;
   int                  empty_hits;
   int                  full_hits;
   int                  range_hits;
   logic [OCC_BITS-1:0] model_count;
   bit                  quiet_phase;
   int                  sent;

   bounded_deque_with_index DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   deque_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked),
      .model_count (model_count),
      .empty_hits  (empty_hits),
      .full_hits   (full_hits),
      .range_hits  (range_hits)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d responses still outstanding", outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // response side: outside quiet phases, stall a random number of cycles before taking each result
   initial begin
      int wait_cycles;
      rsp_tready = 1'b0;
      forever begin
         wait_cycles = quiet_phase ? 0 : $urandom_range(0, 15);
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   task automatic send_item(input op_type op, input logic signed [FIELD_BITS-1:0] word,
                            input logic [POS_BITS-1:0] pos);
      int gap;
      gap = quiet_phase ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, pos, word, op};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent++;
   endtask

   function automatic op_type pick_op(input int mode);
      int roll;
      int push_pct;
      int pop_pct;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_FILL:  begin push_pct = 60; pop_pct = 12; end
         MODE_DRAIN: begin push_pct = 12; pop_pct = 60; end
         default:    begin push_pct = 35; pop_pct = 35; end
      endcase
      if (roll < push_pct)
         pick_op = roll[0] ? OP_PUSH_FRONT : OP_PUSH_BACK;
      else if (roll < push_pct + pop_pct)
         pick_op = roll[0] ? OP_POP_FRONT : OP_POP_BACK;
      else if (roll < 84)
         pick_op = OP_READ_AT;
      else if (roll < 97)
         pick_op = OP_WRITE_AT;
      else
         pick_op = roll[0] ? OP_SPARE_7 : OP_SPARE_6;
   endfunction

   function automatic logic signed [FIELD_BITS-1:0] pick_word();
      case ($urandom_range(0, 11))
         0:       pick_word = 32'sh8000_0000;
         1:       pick_word = 32'sh7fff_ffff;
         2:       pick_word = -32'sd1;
         3:       pick_word = '0;
         default: pick_word = $urandom;
      endcase
   endfunction

   // aim most positions at live entries, the rest anywhere
   function automatic logic [POS_BITS-1:0] pick_pos();
      if (model_count != 0 && $urandom_range(0, 3) != 0)
         pick_pos = POS_BITS'($urandom_range(0, model_count - 1));
      else
         pick_pos = POS_BITS'($urandom_range(0, 15));
   endfunction

   initial begin
      int mode;
      int stretch;
      int drained_wait;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      quiet_phase = 1'b0;
      sent = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty deque: pops, out-of-range read and write, and the spare codes
      send_item(OP_POP_BACK, 32'sd0, 4'd0);
      send_item(OP_POP_FRONT, 32'sd0, 4'd0);
      send_item(OP_READ_AT, 32'sd0, 4'd0);
      send_item(OP_WRITE_AT, 32'sd5, 4'd15);
      send_item(OP_SPARE_6, 32'sd0, 4'd0);
      send_item(OP_SPARE_7, -32'sd1, 4'd15);
      // both ends with extreme words, then indexed access
      send_item(OP_PUSH_BACK, 32'sh7fff_ffff, 4'd0);
      send_item(OP_PUSH_FRONT, 32'sh8000_0000, 4'd0);
      send_item(OP_PUSH_BACK, -32'sd1, 4'd0);
      send_item(OP_PUSH_FRONT, 32'sd0, 4'd0);
      send_item(OP_READ_AT, 32'sd0, 4'd0);
      send_item(OP_READ_AT, 32'sd0, 4'd3);
      send_item(OP_READ_AT, 32'sd0, 4'd4);
      send_item(OP_WRITE_AT, 32'sh5555_5555, 4'd2);
      send_item(OP_READ_AT, 32'sd0, 4'd2);
      send_item(OP_WRITE_AT, 32'sh2aaa_aaaa, 4'd4);
      send_item(OP_POP_BACK, 32'sd0, 4'd0);
      send_item(OP_POP_FRONT, 32'sd0, 4'd0);
      send_item(OP_READ_AT, 32'sd0, 4'd1);
      send_item(OP_POP_FRONT, 32'sd0, 4'd0);
      send_item(OP_POP_BACK, 32'sd0, 4'd0);
      send_item(OP_POP_FRONT, 32'sd0, 4'd0);

      // random phases: fill-biased, drain-biased or mixed
      while (sent < RANDOM_ITEMS) begin
         mode = $urandom_range(MODE_FILL, MODE_MIXED);
         stretch = $urandom_range(20, 60);
         quiet_phase = ($urandom_range(0, 3) == 0);
         repeat (stretch) send_item(pick_op(mode), pick_word(), pick_pos());
      end
      quiet_phase = 1'b0;
      req_tvalid <= 1'b0;

      drained_wait = 0;
      while (outstanding != 0 && drained_wait < 500) begin
         @(negedge clock);
         drained_wait++;
      end
      repeat (8) @(negedge clock);
      if (outstanding != 0)
         $display("%0d responses never arrived", outstanding);

      $display("sent %0d transactions in fill, drain and mixed phases, %0d responses checked",
               sent, checked);
      $display("rejections seen: %0d pops on empty, %0d pushes on full, %0d out of range",
               empty_hits, full_hits, range_hits);
      if (mismatches == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== bounded_deque_with_index.f =====
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_ram.sv
hw/rtl/bounded_deque_with_index.sv
tb/sv/deque_checker.sv
tb/sv/tb_top.sv
